### hdl/pqs_pkg.sv
// Package: types and constants for the PQ distance scan with top-k heap.
`timescale 1ns / 1ps
package pqs_pkg;
	localparam int SUBSPACES = 16;
	localparam int CENTROIDS = 256;
	localparam int HEAP_DEPTH = 32;
	localparam int LUT_DEPTH = SUBSPACES * CENTROIDS;
	localparam int LUT_AW = 12;
	localparam int HEAP_AW = 5;
	localparam int POS_W = 4;
	localparam int CODE_W = 8;
	localparam logic signed [31:0] EMPTY_DIST = 32'sd1000000000;
	localparam logic signed [31:0] EMPTY_ID = -32'sd1;
	localparam logic signed [31:0] DIST_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] DIST_MIN = 32'sh80000000;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOADLUT = 2'd1,
		OP_CODE = 2'd2,
		OP_DRAIN = 2'd3
	} opcode_t;

	localparam logic CFG_TOP_K = 1'b0;
	localparam logic CFG_BASE = 1'b1;

	typedef struct packed {
		logic [1:0] opcode;
		logic [11:0] lut_index;
		logic signed [31:0] lut_value;
		logic [7:0] pq_code;
		logic [30:0] vector_id;
		logic last_code;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result_distance;
		logic signed [31:0] nbr_id;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] distance;
		logic signed [31:0] id;
	} heap_entry_t;

	function automatic logic greater(heap_entry_t a, heap_entry_t b);
		return (a.distance > b.distance) || (a.distance == b.distance && a.id > b.id);
	endfunction

	function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
		logic signed [31:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		if (s > 33'(DIST_MAX)) return DIST_MAX;
		if (s < 33'(DIST_MIN)) return DIST_MIN;
		return s[31:0];
	endfunction
endpackage

### hdl/pqs_lut.sv
// Partial-distance table: 4096 x 32 synchronous RAM.
`timescale 1ns / 1ps
module pqs_lut import pqs_pkg::*; (
	input logic clk,
	input logic we,
	input logic [LUT_AW-1:0] waddr,
	input logic signed [31:0] wdata,
	input logic [LUT_AW-1:0] raddr,
	output logic signed [31:0] rdata
);
	logic signed [31:0] mem [LUT_DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### hdl/pqs_heap.sv
// Top-k heap: one RAM with valid bits, sequencer for clear, sift-down and sorted drain.
`timescale 1ns / 1ps
module pqs_heap import pqs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [5:0] eff_k,
	input logic req_clear,
	input logic req_insert,
	input logic req_drain,
	input heap_entry_t ins_entry,
	output logic busy,
	output heap_entry_t root,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_item
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_ROOT = 8'b00000010,
		S_RDC1 = 8'b00000100,
		S_RDC2 = 8'b00001000,
		S_CMP = 8'b00010000,
		S_SCAN = 8'b00100000,
		S_PICK = 8'b01000000,
		S_EMIT = 8'b10000000
	} state_t;
	state_t state_q;

	heap_entry_t mem [HEAP_DEPTH];
	logic [HEAP_DEPTH-1:0] vld_q;
	logic [HEAP_AW-1:0] raddr;
	heap_entry_t rd_raw, rd;
	logic rd_vld_q;
	logic we;
	logic [HEAP_AW-1:0] waddr;
	heap_entry_t wdata;
	heap_entry_t root_q;
	logic emit_go;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_raw <= mem[raddr];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_vld_q <= 1'b0;
		else rd_vld_q <= vld_q[raddr];
	end
	assign rd = rd_vld_q ? rd_raw : '{distance: EMPTY_DIST, id: EMPTY_ID};

	heap_entry_t ins_q, c1_q, best_q, prev_q;
	logic [5:0] node_q, cidx_q, scan_q, cnt_q, best_idx_q;
	logic prev_ok_q, best_ok_q;
	out_item_t out_q;
	logic out_v_q;

	// entry e is "after" prev in drain order (with index tiebreak for duplicates)
	function automatic logic after_prev(heap_entry_t e, logic [5:0] idx, heap_entry_t p,
		logic [5:0] pidx, logic ok);
		if (!ok) return 1'b1;
		if (greater(e, p)) return 1'b1;
		if (e == p && idx > pidx) return 1'b1;
		return 1'b0;
	endfunction
	function automatic logic before_best(heap_entry_t e, logic [5:0] idx, heap_entry_t b,
		logic [5:0] bidx, logic ok);
		if (!ok) return 1'b1;
		if (greater(b, e)) return 1'b1;
		if (e == b && idx < bidx) return 1'b1;
		return 1'b0;
	endfunction
	logic [5:0] prev_idx_q;

	logic [6:0] c1n, c2n, k_ext;
	assign c1n = {node_q, 1'b0};
	assign c2n = c1n + 7'd1;
	assign k_ext = {1'b0, eff_k};

	always_comb begin
		raddr = '0;
		we = 1'b0;
		waddr = '0;
		wdata = ins_q;
		unique case (state_q)
			S_ROOT, S_RDC1: raddr = HEAP_AW'(c1n - 7'd1);
			S_RDC2: raddr = HEAP_AW'(c2n - 7'd1);
			S_SCAN: raddr = HEAP_AW'(scan_q);
			default: raddr = '0;
		endcase
		if (state_q == S_CMP) begin
			we = 1'b1;
			waddr = HEAP_AW'(node_q - 6'd1);
			if (c1n <= k_ext) begin
				if (c2n > k_ext || greater(c1_q, rd)) begin
					if (!greater(ins_q, c1_q)) wdata = c1_q;
				end else if (!greater(ins_q, rd)) wdata = rd;
			end
		end
	end

	logic cmp_last;
	heap_entry_t cmp_child;
	logic [5:0] cmp_cidx;
	always_comb begin
		cmp_last = 1'b1;
		cmp_child = c1_q;
		cmp_cidx = 6'(c1n);
		if (c1n <= k_ext) begin
			if (!(c2n > k_ext || greater(c1_q, rd))) begin
				cmp_child = rd;
				cmp_cidx = 6'(c2n);
			end
			cmp_last = greater(ins_q, cmp_child);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign root = root_q;
	assign emit_go = (state_q == S_EMIT) && (!out_v_q || !out_stall);
	assign out_valid = out_v_q;
	assign out_item = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_q <= '0;
			root_q <= '{distance: EMPTY_DIST, id: EMPTY_ID};
			out_v_q <= 1'b0;
			node_q <= '0;
			scan_q <= '0;
			cnt_q <= '0;
			prev_ok_q <= 1'b0;
			best_ok_q <= 1'b0;
		end else begin
			if (emit_go) out_v_q <= 1'b1;
			else if (!out_stall) out_v_q <= 1'b0;
			if (we) vld_q[waddr] <= 1'b1;
			if (we && waddr == '0) root_q <= wdata;
			unique case (state_q)
				S_IDLE: begin
					if (req_clear) begin
						vld_q <= '0;
						root_q <= '{distance: EMPTY_DIST, id: EMPTY_ID};
					end else if (req_insert) begin
						ins_q <= ins_entry;
						node_q <= 6'd1;
						state_q <= S_RDC1;
					end else if (req_drain) begin
						cnt_q <= '0;
						prev_ok_q <= 1'b0;
						scan_q <= '0;
						best_ok_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_ROOT: state_q <= S_RDC1;
				S_RDC1: state_q <= S_RDC2;
				S_RDC2: begin
					c1_q <= rd;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (cmp_last) state_q <= S_IDLE;
					else begin
						node_q <= cmp_cidx;
						state_q <= S_RDC1;
					end
				end
				S_SCAN: begin
					scan_q <= scan_q + 6'd1;
					if (scan_q == eff_k - 6'd1) state_q <= S_PICK;
					if (scan_q != '0) begin
						if (after_prev(rd, scan_q - 6'd1, prev_q, prev_idx_q, prev_ok_q) &&
							before_best(rd, scan_q - 6'd1, best_q, best_idx_q, best_ok_q))
						begin
							best_q <= rd;
							best_idx_q <= scan_q - 6'd1;
							best_ok_q <= 1'b1;
						end
					end
				end
				S_PICK: begin
					if (after_prev(rd, scan_q - 6'd1, prev_q, prev_idx_q, prev_ok_q) &&
						before_best(rd, scan_q - 6'd1, best_q, best_idx_q, best_ok_q)) begin
						best_q <= rd;
						best_idx_q <= scan_q - 6'd1;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						out_q.result_distance <= best_q.distance;
						out_q.nbr_id <= best_q.id;
						out_q.last <= (cnt_q == eff_k - 6'd1);
						prev_q <= best_q;
						prev_idx_q <= best_idx_q;
						prev_ok_q <= 1'b1;
						best_ok_q <= 1'b0;
						scan_q <= '0;
						cnt_q <= cnt_q + 6'd1;
						state_q <= (cnt_q == eff_k - 6'd1) ? S_IDLE : S_SCAN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### hdl/pq_distance_topk_scan_core.sv
// Top level: PQ asymmetric distance scan with top-k max-heap and sorted drain.
// CODE reads the table RAM, then adds the word to the running sum; input stalls during the add.
// A last code whose sum is below the root's distance replaces the root and sifts down level by level.
// DRAIN is a selection sort with one heap RAM read per cycle; it waits while the output stalls.
// Reset (arst_n low) empties the heap via valid bits, sets top_k 10, base 0, position 0.
// The table RAM is not reset; entries read before being written are undefined.
`timescale 1ns / 1ps
module pq_distance_topk_scan_core import pqs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [31:0] cfg_data
);
	logic [5:0] top_k_q;
	logic signed [31:0] base_q;
	logic signed [31:0] acc_q;
	logic [POS_W-1:0] pos_q;
	logic code_s1, last_s1;
	logic [30:0] id_s1;
	logic heap_busy;
	logic accept;
	logic signed [31:0] lut_rdata, sum;
	logic [5:0] eff_k;
	heap_entry_t heap_root;
	heap_entry_t ins_entry;
	logic ins;

	assign eff_k = (top_k_q == '0) ? 6'd1 : (top_k_q > 6'd32) ? 6'd32 : top_k_q;
	assign cfg_ready = 1'b1;
	assign in_stall = heap_busy || code_s1;
	assign accept = in_valid && !in_stall;

	pqs_lut u_lut (
		.clk(clk),
		.we(accept && in_data.opcode == OP_LOADLUT),
		.waddr(in_data.lut_index),
		.wdata(in_data.lut_value),
		.raddr({pos_q, in_data.pq_code}),
		.rdata(lut_rdata)
	);

	assign sum = sat_add((pos_q == '0) ? base_q : acc_q, lut_rdata);
	assign ins_entry = '{distance: sum, id: {1'b0, id_s1}};
	assign ins = code_s1 && last_s1 && (heap_root.distance > sum);

	pqs_heap u_heap (
		.clk(clk),
		.arst_n(arst_n),
		.eff_k(eff_k),
		.req_clear(accept && in_data.opcode == OP_CLEAR),
		.req_insert(ins),
		.req_drain(accept && in_data.opcode == OP_DRAIN),
		.ins_entry(ins_entry),
		.busy(heap_busy),
		.root(heap_root),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_k_q <= 6'd10;
			base_q <= '0;
			acc_q <= '0;
			pos_q <= '0;
			code_s1 <= 1'b0;
			last_s1 <= 1'b0;
			id_s1 <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TOP_K) top_k_q <= cfg_data[5:0];
				else base_q <= cfg_data;
			end
			code_s1 <= accept && in_data.opcode == OP_CODE;
			if (accept) begin
				last_s1 <= in_data.last_code;
				id_s1 <= in_data.vector_id;
			end
			if (code_s1) begin
				if (last_s1) begin
					pos_q <= '0;
					acc_q <= base_q;
				end else begin
					acc_q <= sum;
					if (pos_q != POS_W'(SUBSPACES - 1)) pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		ins |=> heap_busy)
		else $error("insert did not start heap sift");
	assert property (@(posedge clk) disable iff (!arst_n)
		code_s1 |-> in_stall)
		else $error("input accepted during table read");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");
endmodule

### test/pq_distance_topk_scan_core_tb.sv
// Testbench: directed and random checks of the PQ distance scan against a top-k predictor.
`timescale 1ns / 1ps
module pq_distance_topk_scan_core_tb;
	import pqs_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [31:0] cfg_data;

	pq_distance_topk_scan_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic signed [31:0] lut_mem [LUT_DEPTH];
	bit lut_written [LUT_DEPTH];
	logic [7:0] loaded_codes [SUBSPACES][$];
	logic signed [31:0] heap_dist [HEAP_DEPTH];
	logic signed [31:0] heap_id [HEAP_DEPTH];
	logic signed [31:0] acc;
	int scan_pos;
	logic [5:0] k_reg;
	logic signed [31:0] base_reg;

	out_item_t expected_neighbors[$];
	int errors = 0;
	bit calm = 0;
	int items_sent = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("pq_distance_topk_scan_core regression: fail");
		$finish;
	end

	function automatic bit dist_gt(logic signed [31:0] d1, logic signed [31:0] i1,
		logic signed [31:0] d2, logic signed [31:0] i2);
		return d1 > d2 || (d1 == d2 && i1 > i2);
	endfunction

	function automatic logic signed [31:0] clamp_add(logic signed [31:0] a,
		logic signed [31:0] b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > longint'(DIST_MAX)) return DIST_MAX;
		if (s < longint'(DIST_MIN)) return DIST_MIN;
		return s[31:0];
	endfunction

	function automatic int active_k();
		if (k_reg == 0) return 1;
		if (k_reg > HEAP_DEPTH) return HEAP_DEPTH;
		return k_reg;
	endfunction

	function automatic void heap_insert_root(int n, logic signed [31:0] d,
		logic signed [31:0] id);
		int i, c1, c2, c;
		i = 1;
		forever begin
			c1 = i * 2;
			c2 = c1 + 1;
			if (c1 > n) break;
			if (c2 > n || dist_gt(heap_dist[c1-1], heap_id[c1-1], heap_dist[c2-1], heap_id[c2-1]))
				c = c1;
			else
				c = c2;
			if (dist_gt(d, id, heap_dist[c-1], heap_id[c-1])) break;
			heap_dist[i-1] = heap_dist[c-1];
			heap_id[i-1] = heap_id[c-1];
			i = c;
		end
		heap_dist[i-1] = d;
		heap_id[i-1] = id;
	endfunction

	function automatic void scan_predict(in_item_t it);
		int n, p, a, b;
		logic signed [31:0] start, sum, id, d;
		logic signed [31:0] sd [HEAP_DEPTH];
		logic signed [31:0] si [HEAP_DEPTH];
		out_item_t r;
		n = active_k();
		case (opcode_t'(it.opcode))
			OP_CLEAR: begin
				for (a = 0; a < HEAP_DEPTH; a++) begin
					heap_dist[a] = EMPTY_DIST;
					heap_id[a] = EMPTY_ID;
				end
			end
			OP_LOADLUT: begin
				if (!lut_written[it.lut_index])
					loaded_codes[it.lut_index / CENTROIDS].push_back(it.lut_index[7:0]);
				lut_mem[it.lut_index] = it.lut_value;
				lut_written[it.lut_index] = 1;
			end
			OP_CODE: begin
				start = (scan_pos == 0) ? base_reg : acc;
				p = (scan_pos >= SUBSPACES) ? SUBSPACES - 1 : scan_pos;
				sum = clamp_add(start, lut_mem[p * CENTROIDS + it.pq_code]);
				id = {1'b0, it.vector_id};
				if (it.last_code) begin
					if (heap_dist[0] > sum) heap_insert_root(n, sum, id);
					acc = base_reg;
					scan_pos = 0;
				end else begin
					acc = sum;
					if (scan_pos < SUBSPACES - 1) scan_pos++;
				end
			end
			OP_DRAIN: begin
				for (a = 0; a < n; a++) begin
					d = heap_dist[a];
					id = heap_id[a];
					b = a;
					while (b > 0 && dist_gt(sd[b-1], si[b-1], d, id)) begin
						sd[b] = sd[b-1];
						si[b] = si[b-1];
						b--;
					end
					sd[b] = d;
					si[b] = id;
				end
				for (a = 0; a < n; a++) begin
					r.result_distance = sd[a];
					r.nbr_id = si[a];
					r.last = (a + 1 == n);
					expected_neighbors.push_back(r);
				end
			end
		endcase
	endfunction

	function automatic bit stall_now();
		return !calm && $urandom_range(99) < 37;
	endfunction

	task automatic send_request(in_item_t it);
		while (stall_now()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		scan_predict(it);
		items_sent++;
	endtask

	function automatic in_item_t noise_item(opcode_t op);
		in_item_t it;
		it.opcode = op;
		it.lut_index = 12'($urandom);
		it.lut_value = $urandom;
		it.pq_code = 8'($urandom);
		it.vector_id = 31'($urandom);
		it.last_code = 1'($urandom);
		return it;
	endfunction

	task automatic send_op(opcode_t op);
		send_request(noise_item(op));
	endtask

	task automatic load_word(int sub, int code, logic signed [31:0] v);
		in_item_t it;
		it = noise_item(OP_LOADLUT);
		it.lut_index = 12'(sub * CENTROIDS + code);
		it.lut_value = v;
		send_request(it);
	endtask

	task automatic send_code(logic [7:0] code, logic [30:0] id, bit fin);
		in_item_t it;
		it = noise_item(OP_CODE);
		it.pq_code = code;
		it.vector_id = id;
		it.last_code = fin;
		send_request(it);
	endtask

	task automatic send_vector(int len, logic [30:0] id);
		int j, p;
		logic [7:0] code;
		for (j = 0; j < len; j++) begin
			p = (scan_pos >= SUBSPACES) ? SUBSPACES - 1 : scan_pos;
			code = loaded_codes[p][$urandom_range(loaded_codes[p].size() - 1)];
			send_code(code, id, j == len - 1);
		end
	endtask

	function automatic logic [30:0] pick_id();
		return ($urandom_range(1)) ? 31'($urandom_range(15)) : 31'($urandom);
	endfunction

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_neighbors.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_TOP_K) k_reg = v[5:0];
		else base_reg = v;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		out_stall <= stall_now();
		if (arst_n && out_valid && !out_stall) begin
			if (expected_neighbors.size() == 0) begin
				$error("unexpected result: distance %0d id %0d",
					out_data.result_distance, out_data.nbr_id);
				errors++;
			end else begin
				if (out_data.result_distance !== expected_neighbors[0].result_distance) begin
					$error("result_distance: expected %0d, got %0d",
						expected_neighbors[0].result_distance, out_data.result_distance);
					errors++;
				end
				if (out_data.nbr_id !== expected_neighbors[0].nbr_id) begin
					$error("nbr_id: expected %0d, got %0d",
						expected_neighbors[0].nbr_id, out_data.nbr_id);
					errors++;
				end
				if (out_data.last !== expected_neighbors[0].last) begin
					$error("last: expected %0d, got %0d",
						expected_neighbors[0].last, out_data.last);
					errors++;
				end
				void'(expected_neighbors.pop_front());
			end
		end
	end

	task automatic test_load_table();
		int s;
		for (s = 0; s < SUBSPACES; s++) begin
			load_word(s, 0, 32'($urandom_range(40)) - 20);
			load_word(s, CENTROIDS - 1, 32'($urandom_range(40)) - 20);
			load_word(s, $urandom_range(1, CENTROIDS - 2), 32'($urandom_range(40)) - 20);
		end
		// extreme words to drive saturation both ways
		load_word(0, 1, DIST_MAX);
		load_word(1, 1, DIST_MIN);
		load_word(2, 1, DIST_MAX);
	endtask

	task automatic test_directed();
		send_op(OP_DRAIN);
		send_code(8'd0, 31'd0, 1'b1);
		send_code(8'd255, 31'h7fffffff, 1'b1);
		send_vector(SUBSPACES, 31'd5);
		send_vector(SUBSPACES + 4, 31'd6);
		send_code(8'd1, 31'd7, 1'b0);
		send_code(8'd1, 31'd7, 1'b1);
		send_code(8'd1, 31'd8, 1'b0);
		send_code(8'd1, 31'd8, 1'b1);
		send_code(8'd0, 31'd3, 1'b1);
		send_code(8'd0, 31'd2, 1'b1);
		send_op(OP_DRAIN);
		send_op(OP_CLEAR);
		send_code(8'd0, 31'd9, 1'b0);
		send_op(OP_CLEAR);
		send_code(8'd0, 31'd9, 1'b1);
		send_op(OP_DRAIN);
		wait_idle();
	endtask

	task automatic test_settings();
		logic [5:0] ks [6] = '{6'd0, 6'd1, 6'd32, 6'd63, 6'd10, 6'd5};
		logic [31:0] bases [6];
		int t, v;
		bases = '{DIST_MIN, 32'd0, DIST_MAX, -32'sd5000, $urandom, 32'd1000000000};
		for (t = 0; t < 6; t++) begin
			calm = (t == 2);
			write_reg(CFG_TOP_K, 32'(ks[t]));
			write_reg(CFG_BASE, bases[t]);
			send_op(OP_CLEAR);
			for (v = 0; v < 3; v++) send_vector($urandom_range(1, 4), pick_id());
			send_op(OP_DRAIN);
			wait_idle();
		end
		calm = 0;
		// k shrinks and grows between vectors of one scan
		write_reg(CFG_TOP_K, 32'd20);
		send_op(OP_CLEAR);
		for (v = 0; v < 6; v++) send_vector($urandom_range(1, 3), pick_id());
		wait_idle();
		write_reg(CFG_TOP_K, 32'd3);
		send_vector(2, pick_id());
		send_op(OP_DRAIN);
		wait_idle();
		write_reg(CFG_TOP_K, 32'd20);
		send_op(OP_DRAIN);
		wait_idle();
	endtask

	task automatic test_random();
		int goal, r;
		goal = items_sent + 45;
		write_reg(CFG_TOP_K, 32'($urandom_range(1, 16)));
		write_reg(CFG_BASE, 32'($urandom_range(200)) - 100);
		while (items_sent < goal) begin
			r = $urandom_range(99);
			if (r < 80)
				send_vector($urandom_range(1, SUBSPACES + 2), pick_id());
			else if (r < 88)
				load_word($urandom_range(SUBSPACES - 1),
					loaded_codes[0][0], 32'($urandom_range(40)) - 20);
			else if (r < 91)
				send_op(OP_CLEAR);
			else if (r < 96)
				send_code(8'd0, pick_id(), 1'b0);
			else
				send_op(OP_DRAIN);
		end
		send_op(OP_DRAIN);
		wait_idle();
	endtask

	initial begin
		int a;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_valid = 0;
		cfg_index = CFG_TOP_K;
		cfg_data = '0;
		k_reg = 6'd10;
		base_reg = '0;
		acc = '0;
		scan_pos = 0;
		for (a = 0; a < HEAP_DEPTH; a++) begin
			heap_dist[a] = EMPTY_DIST;
			heap_id[a] = EMPTY_ID;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load_table();
		test_directed();
		test_settings();
		test_random();
		if (errors == 0)
			$display("pq_distance_topk_scan_core regression: pass");
		else
			$display("pq_distance_topk_scan_core regression: fail");
		$finish;
	end
endmodule

### sim.f
hdl/pqs_pkg.sv
hdl/pqs_lut.sv
hdl/pqs_heap.sv
hdl/pq_distance_topk_scan_core.sv
test/pq_distance_topk_scan_core_tb.sv
